### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/ps2_car_pkg.sv
package ps2_car_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int PORT_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int RETRY_W   = 4;
    localparam int UNREL_W   = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = UNREL_W;

    // Result queue: power-of-two depth, room for two results per item
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Input commands
    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RX      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    // Second port selector
    localparam logic [PORT_W-1:0] PORT_SECOND = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CTRL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNREL_LIMIT = 1'd1;

    // Protocol bytes
    localparam logic [BYTE_W-1:0] BYTE_ACK        = 8'hFA;
    localparam logic [BYTE_W-1:0] BYTE_ECHO       = 8'hEE;
    localparam logic [BYTE_W-1:0] BYTE_RESEND     = 8'hFE;
    localparam logic [BYTE_W-1:0] CTRL_SEND_PORT2 = 8'hD4;
    localparam logic [BYTE_W-1:0] NO_ANSWER       = 8'hFF;

    // Register reset values
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd5;
    localparam logic [UNREL_W-1:0] UNREL_LIMIT_RST = 10'd1000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] command_byte;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] out_byte;
        logic              ok;
        logic              last;
    } t_out_item;

endpackage

### design/ps2_command_ack_retry_unit.sv
// PS/2 host command engine with acknowledge and retry. Each transfer on the
// input channel (start, received byte or timeout) is captured in an input
// register and classified from it once the queue has room; its results
// (none, one, or two for a second-port start or resend: the 0xD4
// controller write and then the data write) go into a four-entry result
// queue that feeds the output channel. One item is taken per clock while
// results drain; the queue and its one-result-per-clock output port (when
// the output is not stalled) set the pace, so items yielding two results
// take two output transfers. Results pass from the input register through
// the result queue to the output. Limits must be written over the plain
// register port only while the engine is idle; the block does not check.
`include "assert_macros.svh"

module ps2_command_ack_retry_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ps2_car_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ps2_car_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  ps2_car_pkg::t_in_item                  i_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output ps2_car_pkg::t_out_item                 o_out
);

    // Configuration
    logic [ps2_car_pkg::RETRY_W-1:0] r_retry_limit;
    logic [ps2_car_pkg::UNREL_W-1:0] r_unrel_limit;

    // Input stage
    logic                  r_in_valid;
    ps2_car_pkg::t_in_item r_in;

    // Exchange state
    logic                              r_busy, n_busy;
    logic                              r_second, n_second;
    logic [ps2_car_pkg::BYTE_W-1:0]    r_pend, n_pend;
    logic [ps2_car_pkg::RETRY_W-1:0]   r_sends, n_sends;
    logic [ps2_car_pkg::UNREL_W-1:0]   r_unrel, n_unrel;
    logic [ps2_car_pkg::BYTE_W-1:0]    r_answer, n_answer;

    // Result queue
    ps2_car_pkg::t_out_item            r_q [ps2_car_pkg::QDEPTH];
    logic [ps2_car_pkg::QPTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [ps2_car_pkg::QCNT_W-1:0]    r_count;

    logic                   room, proc, in_acc, pop;
    logic [1:0]             push_n;
    logic                   send_req, fin_req, fin_ok;
    ps2_car_pkg::t_out_item res0, res1;

    // Handshakes; an item is processed only with room for two results
    assign room        = (r_count <= ps2_car_pkg::QCNT_W'(ps2_car_pkg::QDEPTH - 2));
    assign proc        = r_in_valid && room;
    assign o_in_stall  = r_in_valid && !room;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out       = r_q[r_rd_ptr];
    assign pop         = o_out_valid && !i_out_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= ps2_car_pkg::RETRY_LIMIT_RST;
            r_unrel_limit <= ps2_car_pkg::UNREL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ps2_car_pkg::CFG_RETRY_LIMIT:
                    r_retry_limit <= i_cfg_data[ps2_car_pkg::RETRY_W-1:0];
                ps2_car_pkg::CFG_UNREL_LIMIT:
                    r_unrel_limit <= i_cfg_data[ps2_car_pkg::UNREL_W-1:0];
                default: ;
            endcase
        end
    end

    // Classification and next state
    always_comb begin
        n_busy   = r_busy;
        n_second = r_second;
        n_pend   = r_pend;
        n_sends  = r_sends;
        n_unrel  = r_unrel;
        n_answer = r_answer;
        send_req = 1'b0;
        fin_req  = 1'b0;
        fin_ok   = 1'b0;
        res0     = '0;
        res1     = '0;
        push_n   = 2'd0;

        if (proc) begin
            case (r_in.cmd)
                ps2_car_pkg::CMD_START: begin
                    n_busy   = 1'b1;
                    n_second = (r_in.port == ps2_car_pkg::PORT_SECOND);
                    n_pend   = r_in.command_byte;
                    n_sends  = '0;
                    n_unrel  = '0;
                    n_answer = ps2_car_pkg::NO_ANSWER;
                    send_req = 1'b1;
                end
                ps2_car_pkg::CMD_RX: begin
                    if (r_busy) begin
                        n_answer = r_in.rx_byte;
                        if (r_in.rx_byte == ps2_car_pkg::BYTE_ACK ||
                            r_in.rx_byte == ps2_car_pkg::BYTE_ECHO) begin
                            fin_req = 1'b1;
                            fin_ok  = 1'b1;
                        end else if (r_in.rx_byte == ps2_car_pkg::BYTE_RESEND) begin
                            send_req = 1'b1;
                        end else begin
                            n_unrel = r_unrel + ps2_car_pkg::UNREL_W'(1);
                            fin_req = (n_unrel >= r_unrel_limit);
                        end
                    end
                end
                ps2_car_pkg::CMD_TIMEOUT: begin
                    fin_req = r_busy;
                end
                default: ;
            endcase
        end

        // Send the pending command if the limits still allow it
        if (send_req) begin
            if (n_sends >= r_retry_limit || n_unrel >= r_unrel_limit) begin
                fin_req = 1'b1;
            end else begin
                n_sends = n_sends + ps2_car_pkg::RETRY_W'(1);
                if (n_second) begin
                    res0   = '{ps2_car_pkg::KIND_CTRL, ps2_car_pkg::CTRL_SEND_PORT2,
                               1'b0, 1'b0};
                    res1   = '{ps2_car_pkg::KIND_DATA, n_pend, 1'b0, 1'b1};
                    push_n = 2'd2;
                end else begin
                    res0   = '{ps2_car_pkg::KIND_DATA, n_pend, 1'b0, 1'b1};
                    push_n = 2'd1;
                end
            end
        end

        // Finish result
        if (fin_req) begin
            n_busy = 1'b0;
            res0   = '{ps2_car_pkg::KIND_DONE, n_answer, fin_ok, 1'b1};
            push_n = 2'd1;
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_busy     <= 1'b0;
            r_second   <= 1'b0;
            r_pend     <= '0;
            r_sends    <= '0;
            r_unrel    <= '0;
            r_answer   <= ps2_car_pkg::NO_ANSWER;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            r_in_valid <= in_acc || (r_in_valid && !proc);
            r_busy     <= n_busy;
            r_second   <= n_second;
            r_pend     <= n_pend;
            r_sends    <= n_sends;
            r_unrel    <= n_unrel;
            r_answer   <= n_answer;
            r_wr_ptr   <= r_wr_ptr + ps2_car_pkg::QPTR_W'(push_n);
            r_rd_ptr   <= r_rd_ptr + ps2_car_pkg::QPTR_W'(pop);
            r_count    <= r_count + ps2_car_pkg::QCNT_W'(push_n)
                          - ps2_car_pkg::QCNT_W'(pop);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
        if (push_n != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wr_ptr + ps2_car_pkg::QPTR_W'(1)] <= res1;
        end
    end

    // Checks
    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= ps2_car_pkg::QCNT_W'(ps2_car_pkg::QDEPTH))
    `ASSERT_SAME(a_ctrl_has_data, i_clk, i_rst_n,
        o_out_valid && o_out.kind == ps2_car_pkg::KIND_CTRL,
        r_count >= ps2_car_pkg::QCNT_W'(2) && !o_out.last)
    `ASSERT_NEXT(a_finish_idles, i_clk, i_rst_n, fin_req, !r_busy)
    `ASSERT_SAME(a_empty_no_stall, i_clk, i_rst_n, !r_in_valid, !o_in_stall)

endmodule
